@@ rtl/pkhd_pkg.sv @@
// ----------------------------------------------------------------------------
// pkhd_pkg
// Shared types and constants for the pair-keyed hash dictionary.
// ----------------------------------------------------------------------------
package pkhd_pkg;

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 64;
    localparam int SLOT_W   = 3;
    localparam int CMD_W    = 2;
    localparam int SUM_W    = KEY_W + 1;
    localparam int IN_DW    = 136;  // key, context, slot, value, padded
    localparam int OUT_DW   = 72;   // value, hit, status, padded

    typedef enum logic [CMD_W-1:0] {
        C_WRITE  = 2'd0,
        C_READ   = 2'd1,
        C_CLEAR  = 2'd2,
        C_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_REC,
        S_SLOT,
        S_MISS,
        S_FILL,
        S_DONE
    } t_state;

    // handshake between sequencer and bucket reduction unit
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
    } t_mod_req;

endpackage

@@ rtl/pair_keyed_hash_dictionary.sv @@
// ----------------------------------------------------------------------------
// pair_keyed_hash_dictionary
// Chained hash table keyed by (key_id, context_id), eight value slots each.
// ----------------------------------------------------------------------------
// One item at a time. Bucket = (key + context) mod BUCKETS, by a mask when
// BUCKETS is a power of two, else by a reciprocal multiply. An item then
// passes through the bucket memory read, one record read per record visited
// in the chain, a slot read on a read hit or the miss state when the pair is
// absent, a result load and the idle state before the next beat; a write that
// creates a record also zeroes its other slots and writes the value into its
// slot, one slot at a time through the single slot-memory port. A result
// still waiting in the output register holds the next result back. After
// reset and after every clear, a pass over all BUCKETS entries empties the
// bucket memory; no item is taken meanwhile. Writes that need a new record
// when all RECORDS are in use return status 1.
module pair_keyed_hash_dictionary #(
    parameter int BUCKETS = 256,
    parameter int RECORDS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: key_id[31:0], context_id[63:32], slot[66:64], write_value[130:67]
    input  logic [pkhd_pkg::IN_DW-1:0]  s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [pkhd_pkg::CMD_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata: read_value[63:0], hit[64], status[65]
    output logic [pkhd_pkg::OUT_DW-1:0] m_axis_tdata
);

    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW  = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CW  = $clog2(RECORDS + 1);
    localparam int KW  = pkhd_pkg::KEY_W;
    localparam int VW  = pkhd_pkg::VAL_W;
    localparam int SLW = pkhd_pkg::SLOT_W;
    localparam int AW  = RW + SLW;
    localparam int RECW = 2 * KW + RW + 1;

    // memories
    logic [RW:0]     m_bkt  [BUCKETS];       // {valid, head}
    logic [RECW-1:0] m_rec  [RECORDS];       // {link valid, link, ctx, key}
    logic [VW-1:0]   m_slot [RECORDS * 8];

    pkhd_pkg::t_state r_state, n_state;

    pkhd_pkg::t_cmd    r_cmd;
    logic [KW-1:0]     r_key, r_ctx;
    logic [SLW-1:0]    r_slot, r_k;
    logic [VW-1:0]     r_wval;
    logic [RW-1:0]     r_cur;
    logic [RW:0]       r_head;
    logic [BW-1:0]     r_bkt, r_cnt;
    logic [CW-1:0]     r_used;
    logic              r_clr_res;
    logic [VW-1:0]     r_res_val;
    logic              r_res_hit, r_res_st;
    logic              r_ov;
    logic [pkhd_pkg::OUT_DW-1:0] r_odata;

    logic [RW:0]       bkt_q;
    logic [RECW-1:0]   rec_q;
    logic [VW-1:0]     slot_q;

    pkhd_pkg::t_mod_req mod_req;
    logic               mod_done;
    logic [BW-1:0]      mod_bkt;

    logic            in_acc, out_load, full, match;
    logic            bkt_we, rec_we, slot_we;
    logic [BW-1:0]   bkt_waddr;
    logic [RW:0]     bkt_wdata;
    logic [RW-1:0]   rec_raddr, new_idx;
    logic [AW-1:0]   slot_addr;
    logic [VW-1:0]   slot_wdata;
    logic            rec_lv;
    logic [RW-1:0]   rec_link;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == pkhd_pkg::S_DONE) && (!r_ov || m_axis_tready);
    assign full     = (r_used >= CW'(RECORDS));
    assign new_idx  = r_used[RW-1:0];
    assign rec_lv   = rec_q[RECW-1];
    assign rec_link = rec_q[RECW-2 -: RW];
    assign match    = (rec_q[KW-1:0] == r_key) && (rec_q[2*KW-1:KW] == r_ctx);

    assign mod_req.start = in_acc && ((s_axis_tuser == pkhd_pkg::C_WRITE) ||
                                      (s_axis_tuser == pkhd_pkg::C_READ));
    assign mod_req.sum   = {1'b0, s_axis_tdata[KW-1:0]} +
                           {1'b0, s_axis_tdata[2*KW-1:KW]};

    pkhd_mod #(.BUCKETS(BUCKETS)) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mod_req),
        .o_done   (mod_done),
        .o_bucket (mod_bkt)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pkhd_pkg::S_CLR: begin
                if (r_cnt == BW'(BUCKETS - 1)) begin
                    n_state = r_clr_res ? pkhd_pkg::S_DONE : pkhd_pkg::S_IDLE;
                end
            end
            pkhd_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (pkhd_pkg::t_cmd'(s_axis_tuser))
                        pkhd_pkg::C_WRITE, pkhd_pkg::C_READ: n_state = pkhd_pkg::S_HASH;
                        pkhd_pkg::C_CLEAR:  n_state = pkhd_pkg::S_CLR;
                        default:            n_state = pkhd_pkg::S_DONE;
                    endcase
                end
            end
            pkhd_pkg::S_HASH: if (mod_done) n_state = pkhd_pkg::S_HEAD;
            pkhd_pkg::S_HEAD: n_state = bkt_q[RW] ? pkhd_pkg::S_REC : pkhd_pkg::S_MISS;
            pkhd_pkg::S_REC: begin
                priority if (match) begin
                    n_state = (r_cmd == pkhd_pkg::C_READ) ? pkhd_pkg::S_SLOT
                                                          : pkhd_pkg::S_DONE;
                end else if (rec_lv) begin
                    n_state = pkhd_pkg::S_REC;
                end else begin
                    n_state = pkhd_pkg::S_MISS;
                end
            end
            pkhd_pkg::S_SLOT: n_state = pkhd_pkg::S_DONE;
            pkhd_pkg::S_MISS: begin
                n_state = (r_cmd == pkhd_pkg::C_WRITE && !full) ? pkhd_pkg::S_FILL
                                                                : pkhd_pkg::S_DONE;
            end
            pkhd_pkg::S_FILL: if (r_k == '1) n_state = pkhd_pkg::S_DONE;
            pkhd_pkg::S_DONE: if (out_load) n_state = pkhd_pkg::S_IDLE;
            default:          n_state = pkhd_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        s_axis_tready = (r_state == pkhd_pkg::S_IDLE);
        bkt_we     = 1'b0;
        bkt_waddr  = r_bkt;
        bkt_wdata  = {1'b1, new_idx};
        rec_we     = 1'b0;
        rec_raddr  = r_cur;
        slot_we    = 1'b0;
        slot_addr  = {r_cur, r_slot};
        slot_wdata = r_wval;
        unique case (r_state)
            pkhd_pkg::S_CLR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_cnt;
                bkt_wdata = '0;
            end
            pkhd_pkg::S_HEAD: rec_raddr = bkt_q[RW-1:0];
            pkhd_pkg::S_REC: begin
                rec_raddr = rec_link;
                slot_we   = match && (r_cmd == pkhd_pkg::C_WRITE);
            end
            pkhd_pkg::S_MISS: begin
                bkt_we = (r_cmd == pkhd_pkg::C_WRITE) && !full;
                rec_we = bkt_we;
            end
            pkhd_pkg::S_FILL: begin
                slot_we    = 1'b1;
                slot_addr  = {r_cur, r_k};
                slot_wdata = (r_k == r_slot) ? r_wval : '0;
            end
            default: ;
        endcase
    end

    // memories: registered reads
    always_ff @(posedge i_clk) begin
        bkt_q <= m_bkt[mod_bkt];
        if (bkt_we) begin
            m_bkt[bkt_waddr] <= bkt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        rec_q <= m_rec[rec_raddr];
        if (rec_we) begin
            m_rec[new_idx] <= {r_head, r_ctx, r_key};
        end
    end

    always_ff @(posedge i_clk) begin
        slot_q <= m_slot[slot_addr];
        if (slot_we) begin
            m_slot[slot_addr] <= slot_wdata;
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pkhd_pkg::S_CLR;
            r_cnt     <= '0;
            r_used    <= '0;
            r_clr_res <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pkhd_pkg::S_CLR) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (in_acc) begin
                r_cnt     <= '0;
                r_clr_res <= (s_axis_tuser == pkhd_pkg::C_CLEAR);
                if (s_axis_tuser == pkhd_pkg::C_CLEAR) begin
                    r_used <= '0;
                end
            end
            if (rec_we) begin
                r_used <= r_used + 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= pkhd_pkg::t_cmd'(s_axis_tuser);
            r_key     <= s_axis_tdata[KW-1:0];
            r_ctx     <= s_axis_tdata[2*KW-1:KW];
            r_slot    <= s_axis_tdata[2*KW +: SLW];
            r_wval    <= s_axis_tdata[2*KW+SLW +: VW];
            r_res_val <= '0;
            r_res_hit <= 1'b0;
            r_res_st  <= 1'b0;
        end
        if (mod_done) begin
            r_bkt <= mod_bkt;
        end
        unique case (r_state)
            pkhd_pkg::S_HEAD: begin
                r_head <= bkt_q;
                r_cur  <= bkt_q[RW-1:0];
            end
            pkhd_pkg::S_REC: begin
                if (match) begin
                    r_res_hit <= 1'b1;
                end else begin
                    r_cur <= rec_link;
                end
            end
            pkhd_pkg::S_SLOT: r_res_val <= slot_q;
            pkhd_pkg::S_MISS: begin
                r_cur    <= new_idx;
                r_k      <= '0;
                r_res_st <= (r_cmd == pkhd_pkg::C_WRITE) && full;
            end
            pkhd_pkg::S_FILL: r_k <= r_k + 1'b1;
            default: ;
        endcase
        if (out_load) begin
            r_odata <= {6'b0, r_res_st, r_res_hit, r_res_val};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

    // checks
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(RECORDS))
        else $error("record count beyond capacity");

    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[VW+1]) |-> !m_axis_tdata[VW])
        else $error("status full reported with hit");

    a_new_rec_bkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_we |-> (bkt_we && !full && r_state == pkhd_pkg::S_MISS))
        else $error("record created without head update");

    a_fill_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pkhd_pkg::S_MISS && rec_we) |=> (r_state == pkhd_pkg::S_FILL
            && r_k == '0))
        else $error("new record not zero filled");

endmodule

@@ rtl/pkhd_mod.sv @@
// ----------------------------------------------------------------------------
// pkhd_mod
// Reduces a 33-bit pair sum modulo BUCKETS: a registered mask when BUCKETS is
// a power of two, else a registered reciprocal multiply and back-subtract.
// ----------------------------------------------------------------------------
module pkhd_mod #(
    parameter int BUCKETS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pkhd_pkg::t_mod_req   i_req,
    output logic                 o_done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] o_bucket
);

    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW    = pkhd_pkg::SUM_W;

    logic [BW-1:0] r_rem;
    logic          r_done;

    assign o_done   = r_done;
    assign o_bucket = r_rem;

    if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_req.start;
            end
            if (i_req.start) begin
                r_rem <= BW'(i_req.sum & SW'(BUCKETS - 1));
            end
        end
    end else begin : g_iter
        // q = (x * MUL) >> S is exact for every 33-bit x
        localparam int S  = SW + BW;
        localparam int MW = SW + 1;
        localparam int HW = MW / 2;
        localparam int PW = SW + HW;
        localparam logic [MW-1:0] MUL =
            MW'(((64'd1 << S) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

        logic [SW-1:0] r_x;
        logic [PW-1:0] r_plo, r_phi;
        logic [SW-1:0] r_q;
        logic [2:0]    r_stg;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg  <= '0;
                r_done <= 1'b0;
            end else begin
                r_stg  <= {r_stg[1:0], i_req.start};
                r_done <= r_stg[2];
            end
            if (i_req.start) begin
                r_x <= i_req.sum;
            end
            // two half-width partial products
            if (r_stg[0]) begin
                r_plo <= PW'(r_x) * PW'(MUL[HW-1:0]);
                r_phi <= PW'(r_x) * PW'(MUL[MW-1:HW]);
            end
            if (r_stg[1]) begin
                r_q <= SW'(({r_phi, {HW{1'b0}}} + (PW+HW)'(r_plo)) >> S);
            end
            if (r_stg[2]) begin
                r_rem <= BW'(r_x - SW'(r_q * SW'(BUCKETS)));
            end
        end
    end

endmodule
